>>> rtl/core/midpoint_line_rasterizer_top_assert.svh
// ============================================================================
// Assertion macros for the midpoint line rasterizer
// Concurrent checks clocked on clock, muted while reset is high.
// ============================================================================
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication
`define MPLR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MPLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mplr_pkg.sv
// ============================================================================
// mplr_pkg
// Shared types and constants of the midpoint line rasterizer.
// ============================================================================
package mplr_pkg;

   // Color word, RGBA with R in the high byte
   localparam int COLOR_BITS = 32;
   typedef logic [COLOR_BITS-1:0] color_type;

   // Operation of the shared decision adder
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

endpackage

>>> rtl/core/mplr_alu.sv
// ============================================================================
// mplr_alu
// Shared signed add/subtract unit for setup terms and decision updates.
// ============================================================================
module mplr_alu #(
   parameter int DW = 16
) (
   input  logic                signed [DW-1:0] opa,
   input  logic                signed [DW-1:0] opb,
   input  mplr_pkg::alu_op_type                op,
   output logic                signed [DW-1:0] sum
);

   // Subtract as add of the inverted operand plus one
   logic signed [DW-1:0] opb_eff;
   logic                 carry_in;

   always_comb begin
      unique case (op)
         mplr_pkg::ALU_SUB: begin
            opb_eff  = ~opb;
            carry_in = 1'b1;
         end
         default: begin
            opb_eff  = opb;
            carry_in = 1'b0;
         end
      endcase
   end

   assign sum = opa + opb_eff + DW'(carry_in);

endmodule

>>> rtl/core/midpoint_line_rasterizer_top.sv
// ============================================================================
// midpoint_line_rasterizer_top
// Midpoint line walker: one line command in, one pixel beat per column out.
// ============================================================================
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  req_    | in  | tdata: start_x, start_y, end_x, end_y, color
//  rsp_    | out | tdata: pixel_x, pixel_y, pixel_color; tlast: last pixel
//
//  A command of n pixels (n = |end_x - start_x|) takes its accept cycle, the
//  setup states S_DX, S_SX, S_SXY, S_D0 on the shared adder, then the walk of
//  its pixels while the pixel register can take a beat; the next command is
//  accepted only after that walk ends. A zero-length command is dropped in its
//  accept cycle. A full pixel register with rsp_tready low holds the walk and
//  keeps its beat. reset is synchronous and returns to idle.
//
module midpoint_line_rasterizer_top #(
   parameter int COORD_BITS = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // start_x, start_y, end_x, end_y, color (low to high), zero padded
   input  logic [((4*COORD_BITS+32+7)/8)*8-1:0]   req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // pixel_x, pixel_y, pixel_color (low to high), zero padded
   output logic [((2*COORD_BITS+32+7)/8)*8-1:0]   rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready
);

   localparam int CB    = COORD_BITS;
   localparam int DW    = 2*COORD_BITS + 4;
   localparam int RSP_W = ((2*COORD_BITS + mplr_pkg::COLOR_BITS + 7)/8)*8;

   // Sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DX   = 3'd1;
   localparam logic [2:0] S_SX   = 3'd2;
   localparam logic [2:0] S_SXY  = 3'd3;
   localparam logic [2:0] S_D0   = 3'd4;
   localparam logic [2:0] S_WALK = 3'd5;

   // Request fields
   logic [CB-1:0]       req_ax, req_ay, req_bx, req_by;
   mplr_pkg::color_type req_color;
   logic                req_take;
   logic                req_swap;

   assign req_ax    = req_tdata[CB-1:0];
   assign req_ay    = req_tdata[2*CB-1:CB];
   assign req_bx    = req_tdata[3*CB-1:2*CB];
   assign req_by    = req_tdata[4*CB-1:3*CB];
   assign req_color = req_tdata[4*CB+mplr_pkg::COLOR_BITS-1:4*CB];

   // Control and walk registers
   logic [2:0]           state_ff, state_in;
   logic [CB-1:0]        walk_x_ff, walk_x_in;
   logic [CB-1:0]        walk_y_ff, walk_y_in;
   logic [CB-1:0]        stop_x_ff, stop_x_in;
   logic [CB-1:0]        stop_y_ff, stop_y_in;
   mplr_pkg::color_type  line_color_ff, line_color_in;
   logic signed [DW-1:0] dx_ff, dx_in;
   logic signed [DW-1:0] step_x_ff, step_x_in;
   logic signed [DW-1:0] step_xy_ff, step_xy_in;
   logic signed [DW-1:0] decision_ff, decision_in;

   // Pixel output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]        rsp_x_ff, rsp_x_in;
   logic [CB-1:0]        rsp_y_ff, rsp_y_in;
   mplr_pkg::color_type  rsp_color_ff, rsp_color_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Shared adder
   logic signed [DW-1:0] alu_a, alu_b, alu_sum;
   mplr_pkg::alu_op_type alu_op;

   logic                 rsp_load;
   logic                 walk_last;

   mplr_alu #(
      .DW (DW)
   ) u_alu (
      .opa (alu_a),
      .opb (alu_b),
      .op  (alu_op),
      .sum (alu_sum)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign req_swap   = (req_ax > req_bx);
   assign rsp_load   = (state_ff == S_WALK) && (!rsp_valid_ff || rsp_tready);
   assign walk_last  = (CB'(walk_x_ff + 1'b1) == stop_x_ff);

   // Adder operand select per sequencer step
   always_comb begin
      alu_a  = decision_ff;
      alu_b  = decision_ff[DW-1] ? step_xy_ff : step_x_ff;
      alu_op = mplr_pkg::ALU_ADD;
      unique case (state_ff)
         S_DX: begin
            alu_a  = $signed(DW'(stop_x_ff));
            alu_b  = $signed(DW'(walk_x_ff));
            alu_op = mplr_pkg::ALU_SUB;
         end
         S_SX: begin
            alu_a  = $signed(DW'({walk_y_ff, 1'b0}));
            alu_b  = $signed(DW'({stop_y_ff, 1'b0}));
            alu_op = mplr_pkg::ALU_SUB;
         end
         S_SXY: begin
            alu_a = step_x_ff;
            alu_b = dx_ff <<< 1;
         end
         S_D0: begin
            alu_a = step_x_ff;
            alu_b = dx_ff;
         end
         default: begin
         end
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      walk_x_in     = walk_x_ff;
      walk_y_in     = walk_y_ff;
      stop_x_in     = stop_x_ff;
      stop_y_in     = stop_y_ff;
      line_color_in = line_color_ff;
      dx_in         = dx_ff;
      step_x_in     = step_x_ff;
      step_xy_in    = step_xy_ff;
      decision_in   = decision_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               walk_x_in     = req_swap ? req_bx : req_ax;
               walk_y_in     = req_swap ? req_by : req_ay;
               stop_x_in     = req_swap ? req_ax : req_bx;
               stop_y_in     = req_swap ? req_ay : req_by;
               line_color_in = req_color;
               // zero-length lines produce nothing
               if (req_ax != req_bx) begin
                  state_in = S_DX;
               end
            end
         end
         S_DX: begin
            dx_in    = alu_sum;
            state_in = S_SX;
         end
         S_SX: begin
            step_x_in = alu_sum;
            state_in  = S_SXY;
         end
         S_SXY: begin
            step_xy_in = alu_sum;
            state_in   = S_D0;
         end
         S_D0: begin
            decision_in = alu_sum;
            state_in    = S_WALK;
         end
         S_WALK: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = walk_x_ff;
               rsp_y_in     = walk_y_ff;
               rsp_color_in = line_color_ff;
               rsp_last_in  = walk_last;
               decision_in  = alu_sum;
               walk_x_in    = CB'(walk_x_ff + 1'b1);
               // negative midpoint value: step one row up
               if (decision_ff[DW-1]) begin
                  walk_y_in = CB'(walk_y_ff + 1'b1);
               end
               if (walk_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_x_ff     <= walk_x_in;
      walk_y_ff     <= walk_y_in;
      stop_x_ff     <= stop_x_in;
      stop_y_ff     <= stop_y_in;
      line_color_ff <= line_color_in;
      dx_ff         <= dx_in;
      step_x_ff     <= step_x_in;
      step_xy_ff    <= step_xy_in;
      decision_ff   <= decision_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({rsp_color_ff, rsp_y_ff, rsp_x_ff});

`include "midpoint_line_rasterizer_top_assert.svh"

   `MPLR_ASSERT_SAME(a_idle_no_pixel, state_ff == S_IDLE, !rsp_load, "pixel issued while idle")
   `MPLR_ASSERT_SAME(a_walk_in_range, state_ff == S_WALK, walk_x_ff < stop_x_ff, "walk past end")
   `MPLR_ASSERT_NEXT(a_last_ends_walk, rsp_load && walk_last, state_ff == S_IDLE, "walk not ended")
   `MPLR_ASSERT_NEXT(a_x_advances, rsp_load, walk_x_ff == CB'($past(walk_x_ff) + 1'b1), "x step")
   `MPLR_ASSERT_NEXT(a_y_step, rsp_load, CB'(walk_y_ff - $past(walk_y_ff)) <= 1'b1, "y step")

endmodule
